// ----- hdl/ptw_pkg.sv -----
`default_nettype none

package ptw_pkg;

	localparam int PHYS_ADDR_BITS_DEF = 52;
	localparam int PHYS_ADDR_BITS_MIN = 32;
	localparam int PHYS_ADDR_BITS_MAX = 52;

	localparam int VA_W      = 64;
	localparam int VA_KEEP_W = 48;
	localparam int ENTRY_W   = 64;
	localparam int ADDR_W    = 52;
	localparam int STATUS_W  = 2;
	localparam int IDX_W     = 9;

	localparam int S_TDATA_W = VA_W + ENTRY_W;
	localparam int M_FIELD_W = ADDR_W + ADDR_W + STATUS_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

	localparam int PRESENT_BIT = 0;
	localparam int LARGE_BIT   = 7;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = ADDR_W;
	localparam logic [CFG_INDEX_W-1:0] REG_ENABLE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROOT   = 1'b1;

	localparam logic KIND_XLATE = 1'b0;
	localparam logic KIND_RESP  = 1'b1;

	localparam logic RK_READ = 1'b0;
	localparam logic RK_DONE = 1'b1;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FAULT   = 2'd1;
	localparam status_t ST_REFUSED = 2'd2;

	typedef logic [1:0] level_t;
	localparam level_t LVL_PML4 = 2'd3;
	localparam level_t LVL_PDPT = 2'd2;
	localparam level_t LVL_PD   = 2'd1;
	localparam level_t LVL_PT   = 2'd0;

	typedef struct packed {
		logic                 busy;
		level_t               level;
		logic [VA_KEEP_W-1:0] va;
	} walk_state_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] read_addr;
		logic [ADDR_W-1:0] phys_addr;
		status_t           status;
	} result_t;

	function automatic logic [IDX_W-1:0] level_index(
		input logic [VA_KEEP_W-1:0] va,
		input level_t               level
	);
		logic [IDX_W-1:0] idx;
		case (level)
			LVL_PML4: idx = va[47:39];
			LVL_PDPT: idx = va[38:30];
			LVL_PD:   idx = va[29:21];
			LVL_PT:   idx = va[20:12];
			default:  idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ptw_step.sv -----
`default_nettype none

module ptw_step #(
	parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  wire logic                          kind,
	input  wire logic [ptw_pkg::VA_W-1:0]      va,
	input  wire logic [ptw_pkg::ENTRY_W-1:0]   entry,
	input  wire logic                          enabled,
	input  wire logic [ptw_pkg::ADDR_W-1:0]    root,
	input  wire ptw_pkg::walk_state_t          st,
	output ptw_pkg::walk_state_t               nxt,
	output ptw_pkg::result_t                   res
);
	import ptw_pkg::*;

	logic                      canonical;
	logic                      large_page;
	level_t                    lvl_dn;
	logic [PHYS_ADDR_BITS-1:0] root_base;
	logic [PHYS_ADDR_BITS-1:0] top_addr;
	logic [PHYS_ADDR_BITS-1:0] next_addr;
	logic [PHYS_ADDR_BITS-1:0] pa_gib;
	logic [PHYS_ADDR_BITS-1:0] pa_mib;
	logic [PHYS_ADDR_BITS-1:0] pa_4k;

	assign canonical  = (va[63:47] == '0) || (va[63:47] == '1);
	assign large_page = entry[LARGE_BIT];
	assign lvl_dn     = st.level - 2'd1;

	assign root_base = {root[PHYS_ADDR_BITS-1:12], 12'h000};
	assign top_addr  = root_base
		| PHYS_ADDR_BITS'({level_index(va[VA_KEEP_W-1:0], LVL_PML4), 3'b000});
	assign next_addr = {entry[PHYS_ADDR_BITS-1:12], 12'h000}
		| PHYS_ADDR_BITS'({level_index(st.va, lvl_dn), 3'b000});
	assign pa_gib    = {entry[PHYS_ADDR_BITS-1:30], st.va[29:0]};
	assign pa_mib    = {entry[PHYS_ADDR_BITS-1:21], st.va[20:0]};
	assign pa_4k     = {entry[PHYS_ADDR_BITS-1:12], st.va[11:0]};

	always_comb begin
		nxt           = st;
		res.kind      = RK_DONE;
		res.read_addr = '0;
		res.phys_addr = '0;
		res.status    = ST_OK;
		if (kind == KIND_XLATE) begin
			if (st.busy) begin
				res.status = ST_REFUSED;
			end else if (!enabled || !canonical) begin
				res.status = ST_FAULT;
			end else begin
				nxt.busy      = 1'b1;
				nxt.level     = LVL_PML4;
				nxt.va        = va[VA_KEEP_W-1:0];
				res.kind      = RK_READ;
				res.read_addr = ADDR_W'(top_addr);
			end
		end else begin
			if (!st.busy) begin
				res.status = ST_REFUSED;
			end else if (!entry[PRESENT_BIT]) begin
				nxt.busy   = 1'b0;
				res.status = ST_FAULT;
			end else if (st.level == LVL_PDPT && large_page) begin
				nxt.busy      = 1'b0;
				res.phys_addr = ADDR_W'(pa_gib);
			end else if (st.level == LVL_PD && large_page) begin
				nxt.busy      = 1'b0;
				res.phys_addr = ADDR_W'(pa_mib);
			end else if (st.level == LVL_PT) begin
				nxt.busy      = 1'b0;
				res.phys_addr = ADDR_W'(pa_4k);
			end else begin
				nxt.level     = lvl_dn;
				res.kind      = RK_READ;
				res.read_addr = ADDR_W'(next_addr);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/page_table_walker.sv -----
// Path: input register, combinational step, then the result register, which drives m_tdata.
// Throughput: one beat per cycle; the input register and the result register both
// advance whenever the result register is empty or taken that cycle.
// Reset (arst_n low, asynchronous): walker idle, enable and root cleared, both
// stages empty. No clearing pass.
`default_nettype none

module page_table_walker #(
	parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// virtual_address [63:0], table_entry [127:64]
	input  wire logic [ptw_pkg::S_TDATA_W-1:0]     s_tdata,
	// kind
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// read_address [51:0], physical_address [103:52], status [105:104], zero pad
	output logic [ptw_pkg::M_TDATA_W-1:0]          m_tdata,
	// result_kind
	output logic                                   m_tuser,
	input  wire logic                              cfg_we,
	input  wire logic [ptw_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [ptw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ptw_pkg::*;

	logic                enabled_q;
	logic [ADDR_W-1:0]   root_q;
	walk_state_t         state_q;
	walk_state_t         state_nxt;

	logic                valid_s1;
	logic                kind_s1;
	logic [VA_W-1:0]     va_s1;
	logic [ENTRY_W-1:0]  entry_s1;

	logic                valid_s2;
	result_t             res_s2;
	result_t             res;

	logic                advance;
	logic                fire;

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			root_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enabled_q <= cfg_data[0];
				REG_ROOT:   root_q    <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= s_tuser;
			va_s1    <= s_tdata[VA_W-1:0];
			entry_s1 <= s_tdata[S_TDATA_W-1:VA_W];
		end
	end

	ptw_step #(
		.PHYS_ADDR_BITS(PHYS_ADDR_BITS)
	) u_step (
		.kind    (kind_s1),
		.va      (va_s1),
		.entry   (entry_s1),
		.enabled (enabled_q),
		.root    (root_q),
		.st      (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {{M_PAD_W{1'b0}}, res_s2.status, res_s2.phys_addr, res_s2.read_addr};

	// a read request always leaves a walk running
	a_read_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.kind == RK_READ |=> state_q.busy)
		else $error("read issued without walk in progress");

	// a refused translate leaves the running walk untouched
	a_refuse_keeps_walk: assert property (@(posedge clk) disable iff (!arst_n)
		fire && kind_s1 == KIND_XLATE && state_q.busy
		|=> state_q.busy && $stable(state_q.level) && $stable(state_q.va))
		else $error("refused request disturbed the walk");

	// read requests carry no translation and a good status
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == RK_READ |-> res_s2.status == ST_OK && res_s2.phys_addr == '0)
		else $error("read request with translation or error status");

	// finished results never carry a read address
	a_done_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == RK_DONE |-> res_s2.read_addr == '0)
		else $error("finished result with read address");

endmodule

`default_nettype wire
